FILE: design/tca_pkg.sv
// Shared types and constants for the topological charge accumulator.
// Used by tca_front, tca_back, tca_scale and the top level; depends on nothing.
package tca_pkg;

	localparam int SPIN_W      = 16;   // Q1.15 spin and weight fields
	localparam int DERIV_W     = 36;   // Q6.30 derivative accumulators
	localparam int FRAC_W      = 15;
	localparam int COMP_W      = 22;   // rounded derivative, Q.15, range +-2^20
	localparam int CROSS_W     = 43;   // cross product component, Q.30
	localparam int PROD_W      = 58;   // widest product kept (triple product term)
	localparam int TERM_W      = 59;   // sum of three triple product terms, Q.45
	localparam int SUM_W       = 64;   // group sum, Q19.45
	localparam int OUT_W       = 48;   // Q32.16 charge
	localparam int IN_DATA_W   = 80;
	localparam int MUL_A_W     = 22;
	localparam int MUL_B_W     = 43;
	localparam int INV_W       = 29;
	localparam logic [INV_W-1:0] INV_4PI_Q32 = 29'd341782638;  // round(2^32 / (4 pi))
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		KIND_NEIGHBOUR = 1'b0,
		KIND_CENTRE    = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               last;
		logic signed [15:0] spin_x;
		logic signed [15:0] spin_y;
		logic signed [15:0] spin_z;
		logic signed [15:0] weight_dx;
		logic signed [15:0] weight_dy;
	} item_t;

	// Destination of a registered product in the back end
	typedef enum logic [2:0] {
		TAG_DX   = 3'd0,
		TAG_DY   = 3'd1,
		TAG_CSET = 3'd2,
		TAG_CSUB = 3'd3,
		TAG_TSET = 3'd4,
		TAG_TADD = 3'd5
	} tag_t;

	// Request from the back end to the output scaler
	typedef struct packed {
		logic                     start;
		logic signed [SUM_W-1:0]  value;
	} scl_req_t;

endpackage

FILE: design/tca_front.sv
// Front end: accepts input words, classifies them and holds them in a short queue.
// Depends on tca_pkg.
module tca_front #(
	parameter int QUEUE_DEPTH = tca_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tca_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // spin_x, spin_y, spin_z, weight_dx, weight_dy
	input  logic                           s_axis_tuser,   // operation
	input  logic                           s_axis_tlast,   // last_of_group
	output logic                           q_valid,
	output tca_pkg::item_t                 q_item,
	input  logic                           q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tca_pkg::item_t in_item;
	tca_pkg::item_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	// Classify: weights only matter on neighbour words, the group flag only on centre words
	always_comb begin
		in_item.kind      = s_axis_tuser ? tca_pkg::KIND_CENTRE : tca_pkg::KIND_NEIGHBOUR;
		in_item.last      = s_axis_tlast & s_axis_tuser;
		in_item.spin_x    = s_axis_tdata[15:0];
		in_item.spin_y    = s_axis_tdata[31:16];
		in_item.spin_z    = s_axis_tdata[47:32];
		in_item.weight_dx = s_axis_tuser ? '0 : s_axis_tdata[63:48];
		in_item.weight_dy = s_axis_tuser ? '0 : s_axis_tdata[79:64];
	end

	assign s_axis_tready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid & s_axis_tready;
	assign q_valid       = (cnt_q != '0);
	assign pop           = q_pop & q_valid;
	assign q_item        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/tca_back.sv
// Back end: sequencer around one shared multiplier, derivative and group accumulators.
// Depends on tca_pkg; feeds tca_scale through a tca_pkg::scl_req_t request.
module tca_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  tca_pkg::item_t      q_item,
	output logic                q_pop,
	input  logic                scl_ready,
	output tca_pkg::scl_req_t   scl_req
);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_NB    = 6'b000010,
		PH_CONV  = 6'b000100,
		PH_CROSS = 6'b001000,
		PH_TERM  = 6'b010000,
		PH_FIN   = 6'b100000
	} phase_t;

	localparam int AX = tca_pkg::MUL_A_W - tca_pkg::SPIN_W;
	localparam int BX = tca_pkg::MUL_B_W - tca_pkg::SPIN_W;
	localparam int CX = tca_pkg::MUL_B_W - tca_pkg::COMP_W;

	phase_t phase_q, phase_n;
	logic [2:0] step_q, step_n;
	logic [2:0] step_m3;
	tca_pkg::item_t cur_q;
	logic signed [15:0] spin_c [3];

	logic signed [tca_pkg::DERIV_W-1:0] dx_q [3];
	logic signed [tca_pkg::DERIV_W-1:0] dy_q [3];
	logic signed [tca_pkg::COMP_W-1:0]  a_q [3];
	logic signed [tca_pkg::COMP_W-1:0]  b_q [3];
	logic signed [tca_pkg::COMP_W-1:0]  a_rnd [3];
	logic signed [tca_pkg::COMP_W-1:0]  b_rnd [3];
	logic signed [tca_pkg::CROSS_W-1:0] c_q [3];
	logic signed [tca_pkg::TERM_W-1:0]  term_q;
	logic signed [tca_pkg::SUM_W-1:0]   sum_q;

	logic                                issue;
	logic signed [tca_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [tca_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [tca_pkg::MUL_A_W+tca_pkg::MUL_B_W-1:0] mul_full;
	tca_pkg::tag_t                       tag_n, tag_q;
	logic [1:0]                          idx_n, idx_q;
	logic                                pv_q;
	logic signed [tca_pkg::PROD_W-1:0]   prod_q;

	logic want_next, launch, conv_fire, fin_done;
	logic signed [tca_pkg::DERIV_W-1:0] acc_sel, acc_sat;
	logic signed [tca_pkg::DERIV_W:0]   acc_sum;
	logic signed [tca_pkg::CROSS_W-1:0] prod_c;
	logic signed [tca_pkg::TERM_W-1:0]  prod_t;
	logic signed [tca_pkg::SUM_W:0]     sum_add;
	logic signed [tca_pkg::SUM_W-1:0]   new_sum;

	assign spin_c[0] = cur_q.spin_x;
	assign spin_c[1] = cur_q.spin_y;
	assign spin_c[2] = cur_q.spin_z;
	assign step_m3   = step_q - 3'd3;

	// Round half up to Q.15
	always_comb begin
		logic signed [tca_pkg::DERIV_W:0] rx, ry;
		for (int k = 0; k < 3; k++) begin
			rx = {dx_q[k][tca_pkg::DERIV_W-1], dx_q[k]} + (37'sd1 <<< (tca_pkg::FRAC_W - 1));
			ry = {dy_q[k][tca_pkg::DERIV_W-1], dy_q[k]} + (37'sd1 <<< (tca_pkg::FRAC_W - 1));
			a_rnd[k] = rx[tca_pkg::DERIV_W:tca_pkg::FRAC_W];
			b_rnd[k] = ry[tca_pkg::DERIV_W:tca_pkg::FRAC_W];
		end
	end

	// Operand selection for the shared multiplier
	always_comb begin
		issue = 1'b0;
		mul_a = '0;
		mul_b = '0;
		tag_n = tca_pkg::TAG_DX;
		idx_n = 2'd0;
		unique case (phase_q)
			PH_NB: begin
				issue = 1'b1;
				if (step_q < 3'd3) begin
					idx_n = step_q[1:0];
					tag_n = tca_pkg::TAG_DX;
					mul_a = {{AX{cur_q.weight_dx[15]}}, cur_q.weight_dx};
				end else begin
					idx_n = step_m3[1:0];
					tag_n = tca_pkg::TAG_DY;
					mul_a = {{AX{cur_q.weight_dy[15]}}, cur_q.weight_dy};
				end
				mul_b = {{BX{spin_c[idx_n][15]}}, spin_c[idx_n]};
			end
			PH_CROSS: begin
				issue = 1'b1;
				case (step_q)
					3'd0: begin
						mul_a = a_q[1]; mul_b = {{CX{b_q[2][21]}}, b_q[2]};
						tag_n = tca_pkg::TAG_CSET; idx_n = 2'd0;
					end
					3'd1: begin
						mul_a = a_q[2]; mul_b = {{CX{b_q[1][21]}}, b_q[1]};
						tag_n = tca_pkg::TAG_CSUB; idx_n = 2'd0;
					end
					3'd2: begin
						mul_a = a_q[2]; mul_b = {{CX{b_q[0][21]}}, b_q[0]};
						tag_n = tca_pkg::TAG_CSET; idx_n = 2'd1;
					end
					3'd3: begin
						mul_a = a_q[0]; mul_b = {{CX{b_q[2][21]}}, b_q[2]};
						tag_n = tca_pkg::TAG_CSUB; idx_n = 2'd1;
					end
					3'd4: begin
						mul_a = a_q[0]; mul_b = {{CX{b_q[1][21]}}, b_q[1]};
						tag_n = tca_pkg::TAG_CSET; idx_n = 2'd2;
					end
					default: begin
						mul_a = a_q[1]; mul_b = {{CX{b_q[0][21]}}, b_q[0]};
						tag_n = tca_pkg::TAG_CSUB; idx_n = 2'd2;
					end
				endcase
			end
			PH_TERM: begin
				issue = 1'b1;
				idx_n = step_q[1:0];
				tag_n = (step_q == 3'd0) ? tca_pkg::TAG_TSET : tca_pkg::TAG_TADD;
				mul_a = {{AX{spin_c[idx_n][15]}}, spin_c[idx_n]};
				mul_b = c_q[idx_n];
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// Sequencing
	assign conv_fire = (phase_q == PH_CONV) && !pv_q;
	assign fin_done  = (phase_q == PH_FIN) && !pv_q && (!cur_q.last || scl_ready);
	assign want_next = (phase_q == PH_IDLE) || ((phase_q == PH_NB) && (step_q == 3'd5)) ||
		fin_done;
	assign q_pop     = want_next;
	assign launch    = want_next & q_valid;

	always_comb begin
		phase_n = phase_q;
		step_n  = step_q;
		if (launch) begin
			phase_n = (q_item.kind == tca_pkg::KIND_CENTRE) ? PH_CONV : PH_NB;
			step_n  = 3'd0;
		end else if (want_next) begin
			phase_n = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_NB: begin
					step_n = step_q + 3'd1;
				end
				PH_CONV: begin
					if (conv_fire) begin
						phase_n = PH_CROSS;
						step_n  = 3'd0;
					end
				end
				PH_CROSS: begin
					if (step_q == 3'd5) begin
						phase_n = PH_TERM;
						step_n  = 3'd0;
					end else begin
						step_n = step_q + 3'd1;
					end
				end
				PH_TERM: begin
					if (step_q == 3'd2) begin
						phase_n = PH_FIN;
					end else begin
						step_n = step_q + 3'd1;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= 3'd0;
			pv_q    <= 1'b0;
		end else begin
			phase_q <= phase_n;
			step_q  <= step_n;
			pv_q    <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			cur_q <= q_item;
		end
		prod_q <= mul_full[tca_pkg::PROD_W-1:0];
		tag_q  <= tag_n;
		idx_q  <= idx_n;
	end

	// Saturating derivative update
	assign acc_sel = (tag_q == tca_pkg::TAG_DX) ? dx_q[idx_q] : dy_q[idx_q];
	assign acc_sum = {acc_sel[tca_pkg::DERIV_W-1], acc_sel} +
		{{(tca_pkg::DERIV_W - 31){prod_q[31]}}, prod_q[31:0]};
	assign acc_sat = (acc_sum[tca_pkg::DERIV_W] != acc_sum[tca_pkg::DERIV_W-1]) ?
		{acc_sum[tca_pkg::DERIV_W], {(tca_pkg::DERIV_W - 1){~acc_sum[tca_pkg::DERIV_W]}}} :
		acc_sum[tca_pkg::DERIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				dx_q[k] <= '0;
				dy_q[k] <= '0;
			end
		end else if (conv_fire) begin
			for (int k = 0; k < 3; k++) begin
				dx_q[k] <= '0;
				dy_q[k] <= '0;
			end
		end else if (pv_q) begin
			case (tag_q)
				tca_pkg::TAG_DX: dx_q[idx_q] <= acc_sat;
				tca_pkg::TAG_DY: dy_q[idx_q] <= acc_sat;
				default: ;
			endcase
		end
	end

	// Cross product and triple product accumulation
	assign prod_c = {prod_q[41], prod_q[41:0]};
	assign prod_t = {prod_q[tca_pkg::PROD_W-1], prod_q};

	always_ff @(posedge clk) begin
		if (conv_fire) begin
			for (int k = 0; k < 3; k++) begin
				a_q[k] <= a_rnd[k];
				b_q[k] <= b_rnd[k];
			end
		end
		if (pv_q) begin
			case (tag_q)
				tca_pkg::TAG_CSET: c_q[idx_q] <= prod_c;
				tca_pkg::TAG_CSUB: c_q[idx_q] <= c_q[idx_q] - prod_c;
				tca_pkg::TAG_TSET: term_q <= prod_t;
				tca_pkg::TAG_TADD: term_q <= term_q + prod_t;
				default: ;
			endcase
		end
	end

	// Saturating group sum
	assign sum_add = {sum_q[tca_pkg::SUM_W-1], sum_q} +
		{{(tca_pkg::SUM_W + 1 - tca_pkg::TERM_W){term_q[tca_pkg::TERM_W-1]}}, term_q};
	assign new_sum = (sum_add[tca_pkg::SUM_W] != sum_add[tca_pkg::SUM_W-1]) ?
		{sum_add[tca_pkg::SUM_W], {(tca_pkg::SUM_W - 1){~sum_add[tca_pkg::SUM_W]}}} :
		sum_add[tca_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (fin_done) begin
			sum_q <= cur_q.last ? '0 : new_sum;
		end
	end

	assign scl_req.start = fin_done & cur_q.last;
	assign scl_req.value = new_sum;

endmodule

FILE: design/tca_scale.sv
// Output scaler: group sum times 1/(4 pi) in two 61-bit partial products, result register.
// Depends on tca_pkg.
module tca_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tca_pkg::scl_req_t              req,
	output logic                           ready,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tca_pkg::OUT_W-1:0]      m_axis_tdata    // group_charge
);

	typedef enum logic [5:0] {
		SC_IDLE = 6'b000001,
		SC_ABS  = 6'b000010,
		SC_LO   = 6'b000100,
		SC_HI   = 6'b001000,
		SC_SUM  = 6'b010000,
		SC_OUT  = 6'b100000
	} sc_state_t;

	localparam int PP_W  = 32 + tca_pkg::INV_W;
	localparam int TOT_W = PP_W + 32;

	sc_state_t state_q;
	logic                      neg_q;
	logic [tca_pkg::SUM_W-1:0] mag_q;
	logic [PP_W-1:0]           lo_q, hi_q;
	logic [31:0]               quo_q;
	logic [31:0]               mul_in;
	logic [PP_W-1:0]           mul_p;
	logic [TOT_W-1:0]          total;
	logic [tca_pkg::OUT_W-1:0] quo_ext;
	logic                      ov_q;
	logic [tca_pkg::OUT_W-1:0] data_q;
	logic                      load;

	assign ready   = (state_q == SC_IDLE);
	assign mul_in  = (state_q == SC_LO) ? mag_q[31:0] : mag_q[63:32];
	assign mul_p   = mul_in * tca_pkg::INV_4PI_Q32;
	// Round half away from zero on the magnitude
	assign total   = {hi_q, 32'b0} + {{(TOT_W - PP_W){1'b0}}, lo_q} + (TOT_W'(1) << 60);
	// Magnitude stays below 2^31, so the 48-bit limits are never reached
	assign quo_ext = {{(tca_pkg::OUT_W - 32){1'b0}}, quo_q};
	assign load    = (state_q == SC_OUT) && (!ov_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				SC_IDLE: if (req.start) state_q <= SC_ABS;
				SC_ABS:  state_q <= SC_LO;
				SC_LO:   state_q <= SC_HI;
				SC_HI:   state_q <= SC_SUM;
				SC_SUM:  state_q <= SC_OUT;
				SC_OUT:  if (load) state_q <= SC_IDLE;
				default: state_q <= SC_IDLE;
			endcase
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && req.start) begin
			neg_q <= req.value[tca_pkg::SUM_W-1];
			mag_q <= req.value;
		end
		if (state_q == SC_ABS && neg_q) begin
			mag_q <= '0 - mag_q;
		end
		if (state_q == SC_LO) begin
			lo_q <= mul_p;
		end
		if (state_q == SC_HI) begin
			hi_q <= mul_p;
		end
		if (state_q == SC_SUM) begin
			quo_q <= total[TOT_W-1:61];
		end
		if (load) begin
			data_q <= neg_q ? '0 - quo_ext : quo_ext;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = data_q;

endmodule

FILE: design/topological_charge_accumulator_core.sv
// Top level of the lattice topological charge accumulator.
// Instantiates tca_front, tca_back and tca_scale; depends on tca_pkg.
//
//  channel  | side   | tdata (low bit up)                        | tuser     | tlast
//  ---------+--------+-------------------------------------------+-----------+--------------
//  s_axis   | input  | spin_x, spin_y, spin_z, weight_dx,        | operation | last_of_group
//           |        | weight_dy (16 bits each, 80 bits)         |           |
//  m_axis   | output | group_charge (48 bits, Q32.16)            | -         | -
//
// A neighbour word adds its weighted spins to the x and y derivatives in the back end, one
// product per cycle through the single 22x43 multiplier. A centre word rounds the derivatives,
// forms six cross products and three triple products, then closes the group sum.
// Ending a group also runs the output scaler; the next group end waits on it.
// arst_n clears the queue, the derivative and group accumulators and all sequencers.
// The queue lets the input keep taking words while the back end works; a stalled m_axis
// holds the result register and, once the scaler is also full, the back end at group end.
module topological_charge_accumulator_core #(
	parameter int QUEUE_DEPTH = tca_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tca_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // spin_x, spin_y, spin_z, weight_dx, weight_dy
	input  logic                           s_axis_tuser,   // operation
	input  logic                           s_axis_tlast,   // last_of_group
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tca_pkg::OUT_W-1:0]      m_axis_tdata    // group_charge
);

	logic              q_valid;
	logic              q_pop;
	tca_pkg::item_t    q_item;
	logic              scl_ready;
	tca_pkg::scl_req_t scl_req;

	// Accept and classify words, hold them for the back end
	tca_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// Accumulate derivatives, form the triple product, maintain the group sum
	tca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.scl_ready (scl_ready),
		.scl_req   (scl_req)
	);

	// Scale the finished group sum by 1/(4 pi) and present it on m_axis
	tca_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (scl_req),
		.ready         (scl_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

FILE: tb/topological_charge_accumulator_core_tb.sv
// Self-checking testbench for topological_charge_accumulator_core.
// Sends spin words through s_axis and checks each group charge on m_axis against a local
// fixed-point charge model. Depends on tca_pkg and the core RTL only.
module topological_charge_accumulator_core_tb;

	localparam int     WORDS_TARGET = 1400;
	localparam int     QUIET_WORDS  = 250;
	localparam int     IDLE_LIMIT   = 2000;
	localparam int     TAIL_CYCLES  = 40;
	localparam longint DERIV_HI     = 64'sd34359738367;
	localparam longint DERIV_LO     = -64'sd34359738368;
	localparam longint SUM_HI       = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SUM_LO       = 64'sh8000_0000_0000_0000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [tca_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          s_axis_tlast = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [tca_pkg::OUT_W-1:0]     m_axis_tdata;

	tca_pkg::item_t            spin_words_q[$];
	logic [tca_pkg::OUT_W-1:0] charge_expected_q[$];
	int                        pause_points_q[$];
	tca_pkg::item_t            bus_word;

	// charge model state
	longint dx_acc[3];
	longint dy_acc[3];
	longint site_sum;

	int word_total;
	int quiet_from;
	int offered_cnt;
	int taken_cnt;
	int charges_checked;
	int mismatch_cnt;
	int idle_cycles;
	int tx_gap;
	int rx_stall;
	int site_cnt;
	int group_cnt;
	int long_site_cnt;

	topological_charge_accumulator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	function automatic longint clamp_deriv(input longint v);
		if (v > DERIV_HI) return DERIV_HI;
		if (v < DERIV_LO) return DERIV_LO;
		return v;
	endfunction

	// Q6.30 to Q.15, round half up
	function automatic longint round_deriv(input longint v);
		return (v + 64'sd16384) >>> tca_pkg::FRAC_W;
	endfunction

	// |sum| * round(2^32/(4 pi)), divide by 2^61 rounding half away from zero, then saturate
	function automatic logic [tca_pkg::OUT_W-1:0] scale_charge(input longint v);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] q;
		mag  = (v < 0) ? 64'(-v) : 64'(v);
		prod = 128'(mag) * 128'(tca_pkg::INV_4PI_Q32);
		q    = (prod + (128'd1 << 60)) >> 61;
		if (v < 0) begin
			if (q > (128'd1 << (tca_pkg::OUT_W - 1)))
				q = 128'd1 << (tca_pkg::OUT_W - 1);
			return tca_pkg::OUT_W'(-q);
		end
		if (q > (128'd1 << (tca_pkg::OUT_W - 1)) - 1)
			q = (128'd1 << (tca_pkg::OUT_W - 1)) - 1;
		return tca_pkg::OUT_W'(q);
	endfunction

	task automatic advance_charge_model(input tca_pkg::item_t w);
		longint sp[3];
		longint da[3];
		longint db[3];
		longint cr[3];
		longint term;
		longint nsum;
		sp[0] = longint'(w.spin_x);
		sp[1] = longint'(w.spin_y);
		sp[2] = longint'(w.spin_z);
		if (w.kind == tca_pkg::KIND_NEIGHBOUR) begin
			for (int k = 0; k < 3; k++) begin
				dx_acc[k] = clamp_deriv(dx_acc[k] + longint'(w.weight_dx) * sp[k]);
				dy_acc[k] = clamp_deriv(dy_acc[k] + longint'(w.weight_dy) * sp[k]);
			end
			return;
		end
		for (int k = 0; k < 3; k++) begin
			da[k] = round_deriv(dx_acc[k]);
			db[k] = round_deriv(dy_acc[k]);
		end
		cr[0] = da[1] * db[2] - da[2] * db[1];
		cr[1] = da[2] * db[0] - da[0] * db[2];
		cr[2] = da[0] * db[1] - da[1] * db[0];
		term  = sp[0] * cr[0] + sp[1] * cr[1] + sp[2] * cr[2];
		nsum  = site_sum + term;
		if (site_sum[63] == term[63] && nsum[63] != site_sum[63])
			nsum = term[63] ? SUM_LO : SUM_HI;
		site_sum = nsum;
		for (int k = 0; k < 3; k++) begin
			dx_acc[k] = 0;
			dy_acc[k] = 0;
		end
		if (w.last) begin
			charge_expected_q.insert(charge_expected_q.size(), scale_charge(site_sum));
			site_sum = 0;
		end
	endtask

	task automatic push_word(input tca_pkg::kind_t kind, input logic last, input int sx,
			input int sy, input int sz, input int wx, input int wy);
		tca_pkg::item_t w;
		w.kind      = kind;
		w.last      = last;
		w.spin_x    = 16'(sx);
		w.spin_y    = 16'(sy);
		w.spin_z    = 16'(sz);
		w.weight_dx = 16'(wx);
		w.weight_dy = 16'(wy);
		spin_words_q.insert(spin_words_q.size(), w);
	endtask

	// mostly full-range random, now and then a corner value
	function automatic int pick_value();
		if ($urandom_range(0, 7) != 0)
			return int'($urandom_range(0, 65535));
		case ($urandom_range(0, 4))
			0:       return -32768;
			1:       return 32767;
			2:       return -1;
			3:       return 1;
			default: return 0;
		endcase
	endfunction

	// long sites push the x derivative hard into saturation
	function automatic int biased_spin();
		return ($urandom_range(0, 7) != 0) ? -32768 : int'($urandom_range(0, 65535));
	endfunction

	task automatic queue_site(input bit long_site, input bit close_group);
		int n;
		n = long_site ? $urandom_range(34, 44) : $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			if (long_site)
				push_word(tca_pkg::KIND_NEIGHBOUR, 1'($urandom_range(0, 1)), biased_spin(),
					biased_spin(), biased_spin(), -32768,
					$urandom_range(0, 1) ? 32767 : pick_value());
			else
				push_word(tca_pkg::KIND_NEIGHBOUR, 1'($urandom_range(0, 1)), pick_value(),
					pick_value(), pick_value(),
					($urandom_range(0, 3) == 0) ? 0 : pick_value(),
					($urandom_range(0, 3) == 0) ? 0 : pick_value());
		end
		push_word(tca_pkg::KIND_CENTRE, close_group, pick_value(), pick_value(), pick_value(),
			pick_value(), pick_value());
		site_cnt++;
		if (long_site)
			long_site_cnt++;
		if (close_group)
			group_cnt++;
	endtask

	task automatic build_stimulus();
		int  n_sites;
		bit  mid_marked;
		mid_marked = 1'b0;
		// a site with no neighbours closing its group; centre weights carry no meaning
		push_word(tca_pkg::KIND_CENTRE, 1'b1, 32767, -32768, 1, -32768, 32767);
		// extreme spins and weights, tlast on neighbours is ignored
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, -32768, 32767, 0, -32768, 32767);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b1, 32767, -32768, -32768, 32767, -32768);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 0, -1, 32767, 1, -1);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, -1, -1, -1, -32768, -32768);
		// site that does not end the group: sum carries over
		push_word(tca_pkg::KIND_CENTRE, 1'b0, 32767, -32768, -1, 12345, -4321);
		// rounding ties: +0.5 rounds up, -0.5 rounds to zero
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 16384, 0, 0, 1, 0);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 0, -16384, 0, 0, 3);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 0, 0, 16384, -1, 0);
		push_word(tca_pkg::KIND_CENTRE, 1'b1, 0, 0, -32768, 0, 0);
		// zero weights give a zero term
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b1, 32767, 32767, 32767, 0, 0);
		push_word(tca_pkg::KIND_CENTRE, 1'b1, -32768, -32768, -32768, 0, 0);
		// two sites in one group
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 12000, -5000, 30000, 20000, -31000);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, -7000, 22000, -15000, -9000, 25000);
		push_word(tca_pkg::KIND_CENTRE, 1'b0, 9000, -20000, 11000, 0, 0);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, 30000, 100, -200, -32768, 0);
		push_word(tca_pkg::KIND_NEIGHBOUR, 1'b0, -300, 32000, 400, 0, -32768);
		push_word(tca_pkg::KIND_CENTRE, 1'b1, -1000, 2000, 32767, -1, -1);
		site_cnt  += 6;
		group_cnt += 4;
		// hold the sender here until the directed charges are all out
		pause_points_q.insert(pause_points_q.size(), spin_words_q.size());
		// too many neighbours: derivative accumulators must clip, not wrap
		queue_site(1'b1, 1'b1);
		while (spin_words_q.size() < WORDS_TARGET) begin
			n_sites = $urandom_range(1, 4);
			for (int j = 0; j < n_sites; j++)
				queue_site($urandom_range(0, 14) == 0, j == n_sites - 1);
			if (!mid_marked && spin_words_q.size() >= WORDS_TARGET / 2) begin
				pause_points_q.insert(pause_points_q.size(), spin_words_q.size());
				mid_marked = 1'b1;
			end
		end
		word_total = spin_words_q.size();
		quiet_from = word_total - QUIET_WORDS;
	endtask

	// sender: hold a word until taken, then pick the next one or idle
	always @(negedge clk) begin
		tca_pkg::item_t w;
		bit             waiting;
		bit             bursty;
		waiting = s_axis_tvalid && (offered_cnt != taken_cnt);
		bursty  = ((offered_cnt / 150) % 3) != 2 && offered_cnt < quiet_from;
		if (!arst_n || waiting) begin
		end else if (tx_gap > 0) begin
			tx_gap--;
			s_axis_tvalid <= 1'b0;
		end else if (pause_points_q.size() != 0 && offered_cnt == pause_points_q[0]
				&& charge_expected_q.size() != 0) begin
			s_axis_tvalid <= 1'b0;
		end else if (spin_words_q.size() != 0) begin
			if (pause_points_q.size() != 0 && offered_cnt == pause_points_q[0])
				void'(pause_points_q.pop_front());
			w = spin_words_q.pop_front();
			bus_word      <= w;
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {w.weight_dy, w.weight_dx, w.spin_z, w.spin_y, w.spin_x};
			s_axis_tuser  <= w.kind;
			s_axis_tlast  <= w.last;
			offered_cnt++;
			if (bursty && $urandom_range(0, 3) == 0)
				tx_gap = $urandom_range(1, 8);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// receiver: random stall bursts, none near the end
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if (taken_cnt < quiet_from && ((charges_checked / 8) % 3) != 2
				&& $urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// take words into the model and check charges at the clock edge
	always @(posedge clk) begin
		logic [tca_pkg::OUT_W-1:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_charge_model(bus_word);
				taken_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (charge_expected_q.size() == 0) begin
					report_mismatch($sformatf("group_charge %0d with none expected",
						$signed(m_axis_tdata)));
				end else begin
					want = charge_expected_q.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("group_charge got %0d expected %0d",
							$signed(m_axis_tdata), $signed(want)));
				end
				charges_checked++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(negedge clk);
		$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
		$display("topological_charge_accumulator_core_tb failed");
		$finish;
	end

	initial begin
		for (int k = 0; k < 3; k++) begin
			dx_acc[k] = 0;
			dy_acc[k] = 0;
		end
		site_sum = 0;
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (taken_cnt < word_total || charge_expected_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("sent %0d words over %0d sites (%0d with clipped derivatives) in %0d groups",
			word_total, site_cnt, long_site_cnt, group_cnt);
		$display("checked %0d group charges, %0d mismatches", charges_checked, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("topological_charge_accumulator_core_tb passed");
		else
			$display("topological_charge_accumulator_core_tb failed");
		$finish;
	end

endmodule

FILE: topological_charge_accumulator_core.f
design/tca_pkg.sv
design/tca_front.sv
design/tca_back.sv
design/tca_scale.sv
design/topological_charge_accumulator_core.sv
tb/topological_charge_accumulator_core_tb.sv
